// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the tape record serializer core.
// Expects signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/trbs_pkg.sv =====
// Shared types and constants of the tape record serializer core.
// No dependencies; used by the interfaces and every module.
package trbs_pkg;

   localparam int BIT_IDX_W   = 19;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int NAME_W      = 128;
   localparam int NAME_IDX_W  = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 64;
   localparam int SECTION_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_NAME_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NAME_HIGH = 1'b1;

   localparam logic [SECTION_W-1:0] SEC_ADDR = 3'd0;
   localparam logic [SECTION_W-1:0] SEC_LEN  = 3'd1;
   localparam logic [SECTION_W-1:0] SEC_NAME = 3'd2;
   localparam logic [SECTION_W-1:0] SEC_DATA = 3'd3;
   localparam logic [SECTION_W-1:0] SEC_SUM  = 3'd4;

   // header words are 16 bits, the name block is 16 bytes
   localparam logic [BIT_IDX_W-1:0] HDR_BITS  = 19'd16;
   localparam logic [BIT_IDX_W-1:0] NAME_BITS = 19'd128;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_ADDR = 6'b000010,
      PH_LEN  = 6'b000100,
      PH_NAME = 6'b001000,
      PH_DATA = 6'b010000,
      PH_SUM  = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [BIT_IDX_W-1:0]   bit_index;
      logic [BYTE_W-1:0]      held_byte;
      logic [WORD_W-1:0]      record_length;
      logic [WORD_W-1:0]      running_sum;
      logic                   source_ok;
   } state_type;

   typedef struct packed {
      logic                   bit_out;
      logic                   byte_taken;
      logic [SECTION_W-1:0]   section;
      logic                   record_last;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_IDLE,
      bit_index:     '0,
      held_byte:     '0,
      record_length: '0,
      running_sum:   '0,
      source_ok:     1'b0
   };

endpackage

// ===== rtl/core/trbs_ifs.sv =====
// Valid/ready channel interfaces: strobe requests, result bits, register writes.
// Depends on trbs_pkg for field widths.
interface trbs_req_if;
   import trbs_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [BYTE_W-1:0] source_byte;
   logic              file_present;
   modport source (output valid, output action, output source_byte, output file_present,
                   input ready);
   modport sink   (input valid, input action, input source_byte, input file_present,
                   output ready);
endinterface

interface trbs_rsp_if;
   import trbs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 bit_out;
   logic                 byte_taken;
   logic [SECTION_W-1:0] section;
   logic                 record_last;
   modport source (output valid, output bit_out, output byte_taken, output section,
                   output record_last, input ready);
   modport sink   (input valid, input bit_out, input byte_taken, input section,
                   input record_last, output ready);
endinterface

interface trbs_csr_if;
   import trbs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/core/trbs_csr.sv =====
// Name registers written over the configuration channel.
// Depends on trbs_pkg and trbs_csr_if.
module trbs_csr (
   input  logic                       clock,
   input  logic                       reset,
   trbs_csr_if.sink                   csr_chan,
   output logic [trbs_pkg::NAME_W-1:0] name_bits
);
   import trbs_pkg::*;

   logic [CSR_DATA_W-1:0] name_low_ff, name_low_in;
   logic [CSR_DATA_W-1:0] name_high_ff, name_high_in;
   logic                  wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en = csr_chan.valid & csr_chan.ready;

   always_comb begin
      name_low_in  = name_low_ff;
      name_high_in = name_high_ff;
      if (wr_en) begin
         case (csr_chan.reg_index)
            CSR_NAME_LOW:  name_low_in  = csr_chan.wdata;
            CSR_NAME_HIGH: name_high_in = csr_chan.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_low_ff  <= '0;
         name_high_ff <= '0;
      end else begin
         name_low_ff  <= name_low_in;
         name_high_ff <= name_high_in;
      end
   end

   assign name_bits = {name_high_ff, name_low_ff};

endmodule

// ===== rtl/core/trbs_step.sv =====
// Per-strobe next-state and result logic of the record serializer.
// Depends on trbs_pkg.
module trbs_step (
   input  trbs_pkg::state_type          cur,
   input  logic                         action,
   input  logic [trbs_pkg::BYTE_W-1:0]  source_byte,
   input  logic                         file_present,
   input  logic [trbs_pkg::NAME_W-1:0]  name_bits,
   output trbs_pkg::state_type          nxt,
   output trbs_pkg::result_type         result,
   output logic                         has_result
);
   import trbs_pkg::*;

   state_type            st;
   logic [BIT_IDX_W-1:0] idx_inc;
   logic                 byte_start;
   logic [BYTE_W-1:0]    hb;
   logic [WORD_W:0]      sum_add;

   always_comb begin
      st = cur;
      if (cur.phase == PH_IDLE) begin
         st = STATE_RESET;
         st.phase     = PH_ADDR;
         st.held_byte = cur.held_byte;
         st.source_ok = file_present;
      end

      idx_inc    = st.bit_index + 1'b1;
      byte_start = (st.bit_index[2:0] == 3'd0);
      hb         = st.held_byte;
      sum_add    = '0;
      nxt        = st;
      nxt.bit_index = idx_inc;
      result     = '0;
      has_result = 1'b1;

      case (st.phase)
         PH_ADDR: begin
            result.section = SEC_ADDR;
            if (byte_start) begin
               hb = st.source_ok ? source_byte : '0;
               result.byte_taken = st.source_ok;
            end
            result.bit_out = hb[st.bit_index[2:0]];
            nxt.held_byte  = hb;
            if (idx_inc >= HDR_BITS) begin
               nxt.phase     = PH_LEN;
               nxt.bit_index = '0;
            end
         end
         PH_LEN: begin
            result.section = SEC_LEN;
            if (byte_start) begin
               // no file: length word is 1
               if (st.source_ok) hb = source_byte;
               else              hb = (st.bit_index == '0) ? 8'd1 : 8'd0;
               result.byte_taken = st.source_ok;
               if (st.bit_index[3]) nxt.record_length = {hb, st.record_length[BYTE_W-1:0]};
               else                 nxt.record_length = st.record_length | {8'd0, hb};
            end
            result.bit_out = hb[st.bit_index[2:0]];
            nxt.held_byte  = hb;
            if (idx_inc >= HDR_BITS) begin
               nxt.phase     = PH_NAME;
               nxt.bit_index = '0;
            end
         end
         PH_NAME: begin
            result.section = SEC_NAME;
            result.bit_out = name_bits[st.bit_index[NAME_IDX_W-1:0]];
            if (idx_inc >= NAME_BITS) begin
               nxt.phase     = PH_DATA;
               nxt.bit_index = '0;
            end
         end
         PH_DATA: begin
            result.section = SEC_DATA;
            if (byte_start) begin
               hb = source_byte;
               result.byte_taken = 1'b1;
               // ones-complement style add, carry folds back in
               sum_add = {1'b0, st.running_sum} + {9'd0, hb};
               nxt.running_sum = sum_add[WORD_W-1:0] + {15'd0, sum_add[WORD_W]};
            end
            result.bit_out = hb[st.bit_index[2:0]];
            nxt.held_byte  = hb;
            // zero length wraps the counter to 65536 bytes
            if (idx_inc == {st.record_length, 3'b000}) begin
               if (!st.source_ok) nxt.running_sum = nxt.running_sum + 1'b1;
               nxt.phase     = PH_SUM;
               nxt.bit_index = '0;
            end
         end
         PH_SUM: begin
            result.section = SEC_SUM;
            result.bit_out = st.running_sum[st.bit_index[3:0]];
            if (idx_inc >= HDR_BITS) begin
               result.record_last = 1'b1;
               nxt.phase          = PH_IDLE;
               nxt.bit_index      = '0;
            end
         end
         default: begin
            nxt        = st;
            nxt.phase  = PH_IDLE;
            has_result = 1'b0;
         end
      endcase

      // relay stop: back to idle, nothing else changes
      if (action) begin
         nxt        = cur;
         nxt.phase  = PH_IDLE;
         has_result = 1'b0;
         result     = '0;
      end
   end

endmodule

// ===== rtl/core/trbs_out_reg.sv =====
// Result register between the step logic and the result channel.
// Depends on trbs_pkg and trbs_rsp_if.
module trbs_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  trbs_pkg::result_type  result,
   output logic                  space_ok,
   trbs_rsp_if.source            rsp_chan
);
   import trbs_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // slot frees when its transaction completes in the same cycle
   assign space_ok = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_chan.ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.bit_out     = data_ff.bit_out;
   assign rsp_chan.byte_taken  = data_ff.byte_taken;
   assign rsp_chan.section     = data_ff.section;
   assign rsp_chan.record_last = data_ff.record_last;

endmodule

// ===== rtl/core/tape_record_bit_serializer_core.sv =====
// Tape record bit serializer: one record bit per strobe transaction.
// An accepted strobe's result bit is registered and offered in the cycle after acceptance.
// Throughput: one transaction per cycle while the result slot has space; a held result stalls new strobes.
// An abort transaction gives no result and returns the record state to idle.
// Synchronous reset clears record state, name registers and the result slot.
`include "assert_macros.svh"

module tape_record_bit_serializer_core (
   input  logic         clock,
   input  logic         reset,
   trbs_req_if.sink     req_chan,
   trbs_rsp_if.source   rsp_chan,
   trbs_csr_if.sink     csr_chan
);
   import trbs_pkg::*;

   state_type            state_ff, state_in;
   state_type            step_nxt;
   result_type           step_result;
   logic                 step_has_result;
   logic                 space_ok;
   logic                 req_accept;
   logic [NAME_W-1:0]    name_bits;

   assign req_chan.ready = space_ok;
   assign req_accept     = req_chan.valid & req_chan.ready;

   trbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .name_bits (name_bits)
   );

   trbs_step u_step (
      .cur          (state_ff),
      .action       (req_chan.action),
      .source_byte  (req_chan.source_byte),
      .file_present (req_chan.file_present),
      .name_bits    (name_bits),
      .nxt          (step_nxt),
      .result       (step_result),
      .has_result   (step_has_result)
   );

   assign state_in = req_accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= STATE_RESET;
      else       state_ff <= state_in;
   end

   trbs_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept && step_has_result),
      .result   (step_result),
      .space_ok (space_ok),
      .rsp_chan (rsp_chan)
   );

   `ASSERT_NEXT(a_abort_idle, req_accept && req_chan.action,
                state_ff.phase == PH_IDLE, "abort did not return to idle")
   `ASSERT_IMPL(a_last_in_sum, rsp_chan.valid && rsp_chan.record_last,
                rsp_chan.section == SEC_SUM, "record end outside checksum")
   `ASSERT_IMPL(a_name_no_take, rsp_chan.valid && rsp_chan.section == SEC_NAME,
                !rsp_chan.byte_taken, "byte taken in name section")
   `ASSERT_NEXT(a_last_to_idle, req_accept && !req_chan.action && step_result.record_last,
                state_ff.phase == PH_IDLE, "record end left state active")

endmodule

// ===== test/trbs_record_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the tape record serializer: a bit-level record predictor and
// the queue of expected result bits. Depends on trbs_pkg for types and codes.
package trbs_tb_pkg;
   import trbs_pkg::*;

   localparam logic ACT_STROBE = 1'b0;
   localparam logic ACT_ABORT  = 1'b1;

   typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_kind_type;

   class record_scoreboard;
      logic [NAME_W-1:0]    name_bytes;
      phase_type            phase;
      logic [BIT_IDX_W-1:0] bit_index;
      logic [BYTE_W-1:0]    held_byte;
      logic [WORD_W-1:0]    record_length;
      logic [WORD_W:0]      running_sum;
      logic                 source_ok;
      result_type           expected_bits[$];
      int unsigned          error_count;

      function new();
         name_bytes    = '0;
         phase         = PH_IDLE;
         bit_index     = '0;
         held_byte     = '0;
         record_length = '0;
         running_sum   = '0;
         source_ok     = 1'b0;
         error_count   = 0;
      endfunction

      function void set_name(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_NAME_LOW) begin
            name_bytes[63:0] = data;
         end else begin
            name_bytes[127:64] = data;
         end
      endfunction

      function int pending();
         return expected_bits.size();
      endfunction

      // Advance the record state by one accepted transaction; a strobe queues one bit.
      function void note_strobe(logic action, logic [BYTE_W-1:0] src, logic present);
         result_type r;
         r = '0;
         if (action == ACT_ABORT) begin
            phase = PH_IDLE;
            return;
         end
         if (phase == PH_IDLE) begin
            source_ok     = present;
            phase         = PH_ADDR;
            bit_index     = '0;
            running_sum   = '0;
            record_length = '0;
         end
         case (phase)
            PH_ADDR: begin
               r.section = SEC_ADDR;
               if (bit_index[2:0] == 3'd0) begin
                  held_byte    = source_ok ? src : 8'd0;
                  r.byte_taken = source_ok;
               end
               r.bit_out = held_byte[bit_index[2:0]];
               bit_index = bit_index + 1'b1;
               if (bit_index >= HDR_BITS) begin
                  phase     = PH_LEN;
                  bit_index = '0;
               end
            end
            PH_LEN: begin
               r.section = SEC_LEN;
               if (bit_index[2:0] == 3'd0) begin
                  // without a file the length reads as 1
                  if (source_ok) held_byte = src;
                  else held_byte = (bit_index == '0) ? 8'd1 : 8'd0;
                  r.byte_taken = source_ok;
                  if (bit_index[3]) record_length[15:8] = record_length[15:8] | held_byte;
                  else record_length[7:0] = record_length[7:0] | held_byte;
               end
               r.bit_out = held_byte[bit_index[2:0]];
               bit_index = bit_index + 1'b1;
               if (bit_index >= HDR_BITS) begin
                  phase     = PH_NAME;
                  bit_index = '0;
               end
            end
            PH_NAME: begin
               r.section = SEC_NAME;
               r.bit_out = name_bytes[bit_index[NAME_IDX_W-1:0]];
               bit_index = bit_index + 1'b1;
               if (bit_index >= NAME_BITS) begin
                  phase     = PH_DATA;
                  bit_index = '0;
               end
            end
            PH_DATA: begin
               r.section = SEC_DATA;
               if (bit_index[2:0] == 3'd0) begin
                  held_byte    = src;
                  r.byte_taken = 1'b1;
                  running_sum  = running_sum + held_byte;
                  // end-around carry
                  if (running_sum[WORD_W]) running_sum = {1'b0, running_sum[15:0]} + 1'b1;
               end
               r.bit_out = held_byte[bit_index[2:0]];
               bit_index = bit_index + 1'b1;
               // a zero length compares against 0 only after the index wraps
               if (bit_index == {record_length, 3'b000}) begin
                  if (!source_ok) running_sum = running_sum + 1'b1;
                  phase     = PH_SUM;
                  bit_index = '0;
               end
            end
            default: begin
               r.section = SEC_SUM;
               r.bit_out = running_sum[bit_index[3:0]];
               bit_index = bit_index + 1'b1;
               if (bit_index >= HDR_BITS) begin
                  r.record_last = 1'b1;
                  phase         = PH_IDLE;
                  bit_index     = '0;
               end
            end
         endcase
         expected_bits.push_back(r);
      endfunction

      function void check_bit(result_type got);
         result_type want;
         if (expected_bits.size() == 0) begin
            $error("result with no transaction pending: bit_out %0d section %0d",
                   got.bit_out, got.section);
            error_count++;
            return;
         end
         want = expected_bits.pop_front();
         if (got.bit_out !== want.bit_out) begin
            $error("bit_out: expected %0d, actual %0d", want.bit_out, got.bit_out);
            error_count++;
         end
         if (got.byte_taken !== want.byte_taken) begin
            $error("byte_taken: expected %0d, actual %0d", want.byte_taken, got.byte_taken);
            error_count++;
         end
         if (got.section !== want.section) begin
            $error("section: expected %0d, actual %0d", want.section, got.section);
            error_count++;
         end
         if (got.record_last !== want.record_last) begin
            $error("record_last: expected %0d, actual %0d", want.record_last, got.record_last);
            error_count++;
         end
      endfunction
   endclass

endpackage

// ===== test/tb_tape_record_bit_serializer_core.sv =====
`timescale 1ns / 100ps
// Top-level testbench of tape_record_bit_serializer_core: drives strobe, abort
// and register transactions. Depends on trbs_pkg, the channel interfaces and trbs_tb_pkg.
module tb_tape_record_bit_serializer_core;
   import trbs_pkg::*;
   import trbs_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 300;

   logic clock = 1'b0;
   logic reset;
   logic idling_on;
   int unsigned strobes_sent;
   int unsigned cycle_count;
   int unsigned name_setting;

   record_scoreboard sb = new();

   trbs_req_if req_if ();
   trbs_rsp_if rsp_if ();
   trbs_csr_if csr_if ();

   tape_record_bit_serializer_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // monitor: all transactions sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_bit('{bit_out: rsp_if.bit_out, byte_taken: rsp_if.byte_taken,
                           section: rsp_if.section, record_last: rsp_if.record_last});
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_strobe(req_if.action, req_if.source_byte, req_if.file_present);
         end
         if (csr_if.valid && csr_if.ready) begin
            sb.set_name(csr_if.reg_index, csr_if.wdata);
         end
      end
   end

   // result side back-pressure in random stall bursts, only while idling is on
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!idling_on) begin
            rsp_if.ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left = $urandom_range(0, 4);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic action, input logic [BYTE_W-1:0] src,
                            input logic present);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_if.valid        = 1'b1;
      req_if.action       = action;
      req_if.source_byte  = src;
      req_if.file_present = present;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      if (action == ACT_STROBE) strobes_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_if.valid     = 1'b1;
      csr_if.reg_index = index;
      csr_if.wdata     = data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // sender holds off until every pending bit is back; aborts leave no result
   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic next_names();
      logic [CSR_DATA_W-1:0] lo, hi;
      case (name_setting % 4)
         0: begin lo = '0; hi = '0; end
         1: begin lo = '1; hi = '1; end
         2: begin lo = {32{2'b01}}; hi = {32{2'b10}}; end
         default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      endcase
      name_setting++;
      wait_drained();
      write_csr(CSR_NAME_LOW, lo);
      write_csr(CSR_NAME_HIGH, hi);
   endtask

   // One record from idle; a cut below the record size aborts after that many strobes.
   task automatic send_record(input logic present, input int unsigned len,
                              input logic [WORD_W-1:0] addr, input int cut,
                              input fill_kind_type fill);
      int unsigned nbytes;
      int total, s;
      logic [BYTE_W-1:0] src;
      logic [WORD_W-1:0] len_word;
      len_word = len[15:0];
      nbytes = present ? ((len_word == 0) ? 65536 : len_word) : 1;
      total = 176 + nbytes * 8;
      for (s = 0; s < total; s++) begin
         if (s == cut) break;
         src = 8'($urandom);
         if (s == 0) src = addr[7:0];
         else if (s == 8) src = addr[15:8];
         else if (s == 16) src = len_word[7:0];
         else if (s == 24) src = len_word[15:8];
         else if (s >= 160 && (s - 160) % 8 == 0 && s < total - 16) begin
            if (fill == FILL_ONES) src = 8'hFF;
            else if (fill == FILL_ZEROS) src = 8'h00;
         end
         send_item(ACT_STROBE, src, (s == 0) ? present : 1'($urandom_range(0, 1)));
      end
      if (cut >= 0) send_item(ACT_ABORT, 8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      int unsigned base, iter, kind, len;
      fill_kind_type fill;
      reset = 1'b1;
      idling_on = 1'b1;
      strobes_sent = 0;
      name_setting = 1;
      req_if.valid = 1'b0;
      req_if.action = ACT_STROBE;
      req_if.source_byte = '0;
      req_if.file_present = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.reg_index = CSR_NAME_LOW;
      csr_if.wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: abort while idle, no-file record, header extremes, restart after abort
      send_item(ACT_ABORT, 8'hFF, 1'b1);
      next_names();
      send_record(1'b0, 7, 16'h1234, -1, FILL_ONES);
      send_record(1'b1, 1, 16'hFFFF, -1, FILL_ZEROS);
      send_record(1'b1, 16'h0102, 16'h0000, 40, FILL_RANDOM);
      send_record(1'b1, 2, 16'h8001, 170, FILL_ONES);

      base = strobes_sent;
      iter = 0;
      while (strobes_sent - base < RANDOM_ITEMS) begin
         if (iter % 3 == 2) next_names();
         iter++;
         idling_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         len = $urandom_range(1, 5);
         case ($urandom_range(0, 5))
            0: fill = FILL_ONES;
            1: fill = FILL_ZEROS;
            default: fill = FILL_RANDOM;
         endcase
         if (kind <= 5) begin
            send_record(1'($urandom_range(0, 3) != 0), len, 16'($urandom), -1, fill);
         end else if (kind <= 8) begin
            send_record(1'($urandom_range(0, 3) != 0), len, 16'($urandom),
                        $urandom_range(0, 220), fill);
         end else begin
            repeat ($urandom_range(1, 8))
               send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
            send_item(ACT_ABORT, 8'($urandom), 1'($urandom_range(0, 1)));
         end
      end

      // last stretch without idling: a zero length record keeps streaming data
      // well past the header, then is aborted
      idling_on = 1'b0;
      next_names();
      send_record(1'b1, 0, 16'($urandom), 300, FILL_RANDOM);
      req_if.valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.error_count++;
      end
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/trbs_pkg.sv
rtl/core/trbs_ifs.sv
rtl/core/trbs_csr.sv
rtl/core/trbs_step.sv
rtl/core/trbs_out_reg.sv
rtl/core/tape_record_bit_serializer_core.sv
test/trbs_record_scoreboard.sv
test/tb_tape_record_bit_serializer_core.sv
